// ===== hdl/imconv_pkg.sv =====
// Package for the 3x3 image convolution block.
// Holds widths, register reset values, register index codes and coefficient extraction.
// No dependencies.
package imconv_pkg;

    localparam int KERNEL_SIZE   = 3;
    localparam int MAX_WIDTH_DEF = 2048;

    localparam int PIX_W     = 8;
    localparam int WIDTH_W   = 12;
    localparam int HEIGHT_W  = 16;
    localparam int COEF_W    = 16;
    localparam int KROW_W    = KERNEL_SIZE * COEF_W;
    localparam int ROW_W     = 17;
    localparam int PROD_W    = PIX_W + 1 + COEF_W;
    localparam int SUM_W     = 28;
    localparam int OUT_ROW_W = 16;
    localparam int OUT_COL_W = 11;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 6;

    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 12'd640;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 16'd480;
    localparam logic [KROW_W-1:0]   RST_KTOP   = 48'd549755879296;
    localparam logic [KROW_W-1:0]   RST_KMID   = 48'd1099511693056;
    localparam logic [KROW_W-1:0]   RST_KBOT   = 48'd549755879296;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_KTOP   = 3'd2,
        REG_KMID   = 3'd3,
        REG_KBOT   = 3'd4
    } t_reg_idx;

    typedef logic [PIX_W-1:0] t_pix;

    // Coefficient of column col from one packed kernel row, left column in the low bits.
    function automatic logic signed [COEF_W-1:0] coef(input logic [KROW_W-1:0] krow,
                                                      input int col);
        coef = krow[col*COEF_W +: COEF_W];
    endfunction

endpackage

// ===== hdl/image_convolution_3x3.sv =====
// 3x3 streaming image correlation with zero padding, top level.
// Holds the register file, line stores, window, multipliers and adder.
// Depends on imconv_pkg.
//
// Usage: pixels enter in raster order on the i_pix_valid / o_pix_ready channel,
// one transaction per pixel. After the W*H pixels of a frame the sender gives
// W+1 transactions with i_flush high to drain the bottom row. Results leave on
// o_res_valid / i_res_ready; the result for centre pixel (R, C) is produced by
// input transaction R*W + C + W + 1 of the frame, so the first W+1 inputs of a
// frame give nothing. o_frame_last marks the final result of a frame, after
// which the position counters restart.
// The transaction that completes a result goes through the line store read,
// the multiply stage and the adder/output register before it is on the output.
// Throughput: one pixel per cycle unless the output stalls; line stores take one
// read and one write per cycle each, the upper write from stage 1 with bypass.
// Reset: synchronous, active low; registers take their reset values, the
// pipeline empties and the line stores read as zero until written.
// Stall: when i_res_ready is low the result holds; input is taken while
// bubbles remain in the pipeline, then o_pix_ready drops.
// Registers are written over the APB port at byte address 8*index.
module image_convolution_3x3 #(
    parameter int MAX_WIDTH = imconv_pkg::MAX_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [imconv_pkg::ADDR_W-1:0]          paddr,
    input  logic [imconv_pkg::DATA_W-1:0]          pwdata,
    output logic [imconv_pkg::DATA_W-1:0]          prdata,
    output logic                                   pready,
    input  logic                                   i_pix_valid,
    output logic                                   o_pix_ready,
    input  logic [imconv_pkg::PIX_W-1:0]           i_pixel,
    input  logic                                   i_flush,
    output logic                                   o_res_valid,
    input  logic                                   i_res_ready,
    output logic signed [imconv_pkg::SUM_W-1:0]    o_filtered,
    output logic [imconv_pkg::PIX_W-1:0]           o_clamped_pixel,
    output logic [imconv_pkg::OUT_ROW_W-1:0]       o_result_row,
    output logic [imconv_pkg::OUT_COL_W-1:0]       o_result_column,
    output logic                                   o_frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int WW    = (CNT_W > imconv_pkg::WIDTH_W) ? CNT_W : imconv_pkg::WIDTH_W;
    localparam int ROW_W = imconv_pkg::ROW_W;
    localparam int NWIN  = imconv_pkg::KERNEL_SIZE * imconv_pkg::KERNEL_SIZE;
    localparam int KS    = imconv_pkg::KERNEL_SIZE;

    // ---------------- register file ----------------
    logic [imconv_pkg::WIDTH_W-1:0]  r_image_width;
    logic [imconv_pkg::HEIGHT_W-1:0] r_image_height;
    logic [imconv_pkg::KROW_W-1:0]   r_kernel [0:KS-1];
    logic                            cfg_wr;
    imconv_pkg::t_reg_idx            reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = imconv_pkg::t_reg_idx'(paddr[imconv_pkg::ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= imconv_pkg::RST_WIDTH;
            r_image_height <= imconv_pkg::RST_HEIGHT;
            r_kernel[0]    <= imconv_pkg::RST_KTOP;
            r_kernel[1]    <= imconv_pkg::RST_KMID;
            r_kernel[2]    <= imconv_pkg::RST_KBOT;
        end else if (cfg_wr) begin
            case (reg_idx)
                imconv_pkg::REG_WIDTH:  r_image_width  <= pwdata[imconv_pkg::WIDTH_W-1:0];
                imconv_pkg::REG_HEIGHT: r_image_height <= pwdata[imconv_pkg::HEIGHT_W-1:0];
                imconv_pkg::REG_KTOP:   r_kernel[0]    <= pwdata[imconv_pkg::KROW_W-1:0];
                imconv_pkg::REG_KMID:   r_kernel[1]    <= pwdata[imconv_pkg::KROW_W-1:0];
                imconv_pkg::REG_KBOT:   r_kernel[2]    <= pwdata[imconv_pkg::KROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            imconv_pkg::REG_WIDTH:  prdata = imconv_pkg::DATA_W'(r_image_width);
            imconv_pkg::REG_HEIGHT: prdata = imconv_pkg::DATA_W'(r_image_height);
            imconv_pkg::REG_KTOP:   prdata = imconv_pkg::DATA_W'(r_kernel[0]);
            imconv_pkg::REG_KMID:   prdata = imconv_pkg::DATA_W'(r_kernel[1]);
            imconv_pkg::REG_KBOT:   prdata = imconv_pkg::DATA_W'(r_kernel[2]);
            default:                prdata = '0;
        endcase
    end

    // effective frame size
    logic [WW-1:0]                   w_eff;
    logic [imconv_pkg::HEIGHT_W-1:0] h_eff;

    always_comb begin
        if (r_image_width == '0) begin
            w_eff = WW'(1);
        end else if (WW'(r_image_width) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_image_width);
        end
        h_eff = (r_image_height == '0) ? imconv_pkg::HEIGHT_W'(1) : r_image_height;
    end

    // ---------------- pipeline control ----------------
    logic r_v1, r_v2, r_vo;
    logic r_s1_emit;
    logic free_o, free2, free1, adv1, accept;

    assign free_o      = !r_vo || i_res_ready;
    assign free2       = !r_v2 || free_o;
    assign adv1        = r_v1 && (!r_s1_emit || free2);
    assign free1       = !r_v1 || adv1;
    assign o_pix_ready = free1;
    assign accept      = i_pix_valid && free1;

    // ---------------- position counters (input stage) ----------------
    logic [COL_W-1:0] r_col, n_col, ic, ccol0;
    logic [ROW_W-1:0] r_row, n_row, ir, crow0;
    logic [WW-1:0]    col_inc;
    logic             wrap, ic_nz, emit0, last0;
    logic [CNT_W-1:0] r_fill_lo, r_fill_up;
    logic             lo_ok0, up_ok0;
    imconv_pkg::t_pix pix_in;

    always_comb begin
        wrap    = WW'(r_col) >= w_eff;
        ic      = wrap ? '0 : r_col;
        ir      = wrap ? r_row + ROW_W'(1) : r_row;
        ic_nz   = ic != '0;
        emit0   = ic_nz ? (ir != '0) : (ir >= ROW_W'(2));
        crow0   = ic_nz ? ir - ROW_W'(1) : ir - ROW_W'(2);
        ccol0   = ic_nz ? ic - COL_W'(1) : COL_W'(w_eff - WW'(1));
        last0   = !ic_nz && (ir > ROW_W'(h_eff));
        col_inc = WW'(ic) + WW'(1);
        if (last0) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (ir != '1) ? ir + ROW_W'(1) : ir;
        end else begin
            n_col = COL_W'(col_inc);
            n_row = ir;
        end
        lo_ok0 = CNT_W'(ic) < r_fill_lo;
        up_ok0 = CNT_W'(ic) < r_fill_up;
        pix_in = i_flush ? '0 : i_pixel;
    end

    // fill counts: both stores are written in ascending prefixes from column 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_fill_lo <= '0;
            r_fill_up <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (CNT_W'(ic) == r_fill_lo) begin
                r_fill_lo <= r_fill_lo + CNT_W'(1);
            end
            if (CNT_W'(ic) == r_fill_up && lo_ok0) begin
                r_fill_up <= r_fill_up + CNT_W'(1);
            end
        end
    end

    // ---------------- line stores ----------------
    imconv_pkg::t_pix mem_lo [0:MAX_WIDTH-1];
    imconv_pkg::t_pix mem_up [0:MAX_WIDTH-1];
    imconv_pkg::t_pix r_lo_q, r_up_q;
    imconv_pkg::t_pix prev1, above1;

    logic [COL_W-1:0] r_s1_ic;
    logic [COL_W-1:0] r_s1_ccol;
    logic [ROW_W-1:0] r_s1_crow;
    imconv_pkg::t_pix r_s1_pix, r_s1_fwd_pix;
    logic             r_s1_last, r_s1_lo_ok, r_s1_up_ok, r_s1_fwd;
    logic             n_fwd;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lo_q     <= mem_lo[ic];
            mem_lo[ic] <= pix_in;
        end
    end

    // upper store takes the old lower value from the stage-1 register when that stage advances
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up_q <= mem_up[ic];
        end
        if (adv1) begin
            mem_up[r_s1_ic] <= prev1;
        end
    end

    assign n_fwd  = r_v1 && (r_s1_ic == ic);
    assign prev1  = r_s1_lo_ok ? r_lo_q : '0;
    assign above1 = r_s1_fwd ? r_s1_fwd_pix : (r_s1_up_ok ? r_up_q : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (free1) begin
            r_v1 <= i_pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ic      <= ic;
            r_s1_pix     <= pix_in;
            r_s1_emit    <= emit0;
            r_s1_last    <= last0;
            r_s1_crow    <= crow0;
            r_s1_ccol    <= ccol0;
            r_s1_lo_ok   <= lo_ok0;
            r_s1_up_ok   <= up_ok0;
            r_s1_fwd     <= n_fwd;
            r_s1_fwd_pix <= prev1;
        end
    end

    // ---------------- window and multipliers ----------------
    imconv_pkg::t_pix r_win [0:NWIN-1];
    imconv_pkg::t_pix n_win [0:NWIN-1];
    logic             row_ok [0:KS-1];
    logic             col_ok [0:KS-1];
    logic signed [imconv_pkg::PROD_W-1:0] n_prod [0:NWIN-1];
    logic signed [imconv_pkg::PROD_W-1:0] r_prod [0:NWIN-1];

    always_comb begin
        for (int y = 0; y < KS; y++) begin
            n_win[y*KS]     = r_win[y*KS + 1];
            n_win[y*KS + 1] = r_win[y*KS + 2];
        end
        n_win[2] = above1;
        n_win[5] = prev1;
        n_win[8] = r_s1_pix;

        row_ok[0] = r_s1_crow != '0;
        row_ok[1] = 1'b1;
        row_ok[2] = ({1'b0, r_s1_crow} + (ROW_W+1)'(1)) < (ROW_W+1)'(h_eff);
        col_ok[0] = r_s1_ccol != '0;
        col_ok[1] = 1'b1;
        col_ok[2] = (WW'(r_s1_ccol) + WW'(1)) < w_eff;

        for (int y = 0; y < KS; y++) begin
            for (int x = 0; x < KS; x++) begin
                if (row_ok[y] && col_ok[x]) begin
                    n_prod[y*KS + x] = $signed({1'b0, n_win[y*KS + x]})
                                     * imconv_pkg::coef(r_kernel[y], x);
                end else begin
                    n_prod[y*KS + x] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NWIN; i++) begin
                r_win[i] <= '0;
            end
        end else if (adv1) begin
            r_win <= n_win;
        end
    end

    logic [imconv_pkg::OUT_ROW_W-1:0] r_s2_row;
    logic [imconv_pkg::OUT_COL_W-1:0] r_s2_col;
    logic                             r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (free2) begin
            r_v2 <= r_v1 && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && r_s1_emit) begin
            r_prod    <= n_prod;
            r_s2_row  <= r_s1_crow[imconv_pkg::OUT_ROW_W-1:0];
            r_s2_col  <= imconv_pkg::OUT_COL_W'(r_s1_ccol);
            r_s2_last <= r_s1_last;
        end
    end

    // ---------------- adder and saturation ----------------
    logic signed [imconv_pkg::SUM_W-1:0] sum;
    imconv_pkg::t_pix                    clamp;

    always_comb begin
        sum = '0;
        for (int i = 0; i < NWIN; i++) begin
            sum = sum + imconv_pkg::SUM_W'(r_prod[i]);
        end
        if (sum[imconv_pkg::SUM_W-1]) begin
            clamp = '0;
        end else if (|sum[imconv_pkg::SUM_W-2:16]) begin
            clamp = '1;
        end else begin
            clamp = sum[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (free_o) begin
            r_vo <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && free_o) begin
            o_filtered      <= sum;
            o_clamped_pixel <= clamp;
            o_result_row    <= r_s2_row;
            o_result_column <= r_s2_col;
            o_frame_last    <= r_s2_last;
        end
    end

    assign o_res_valid = r_vo;

    // ---------------- assertions ----------------
    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_up <= r_fill_lo)
        else $error("upper store fill count ahead of lower store");

    a_upper_needs_lower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_s1_up_ok |-> r_s1_lo_ok)
        else $error("upper store entry valid without lower entry");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && last0 |=> r_col == '0 && r_row == '0)
        else $error("counters did not restart after last transaction of frame");

    a_clamp_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_filtered[imconv_pkg::SUM_W-1] |-> o_clamped_pixel == '0)
        else $error("negative sum not clamped to zero");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_col) < CNT_W'(MAX_WIDTH))
        else $error("column counter beyond line store depth");

endmodule

// ===== bench/tb.sv =====
// Testbench for image_convolution_3x3: directed and random frames checked against
// a built-in prediction of the 3x3 window sum, clamp, position and frame end.
// Depends on imconv_pkg and the image_convolution_3x3 RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int LINE_DEPTH    = imconv_pkg::MAX_WIDTH_DEF;

    typedef struct {
        logic signed [imconv_pkg::SUM_W-1:0]  filtered;
        logic [imconv_pkg::PIX_W-1:0]         clamped;
        logic [imconv_pkg::OUT_ROW_W-1:0]     row;
        logic [imconv_pkg::OUT_COL_W-1:0]     col;
        logic                                 last;
    } t_conv_result;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  psel = 1'b0;
    logic                                  penable = 1'b0;
    logic                                  pwrite = 1'b0;
    logic [imconv_pkg::ADDR_W-1:0]         paddr = '0;
    logic [imconv_pkg::DATA_W-1:0]         pwdata = '0;
    logic [imconv_pkg::DATA_W-1:0]         prdata;
    logic                                  pready;
    logic                                  i_pix_valid = 1'b0;
    logic                                  o_pix_ready;
    logic [imconv_pkg::PIX_W-1:0]          i_pixel = '0;
    logic                                  i_flush = 1'b0;
    logic                                  o_res_valid;
    logic                                  i_res_ready = 1'b0;
    logic signed [imconv_pkg::SUM_W-1:0]   o_filtered;
    logic [imconv_pkg::PIX_W-1:0]          o_clamped_pixel;
    logic [imconv_pkg::OUT_ROW_W-1:0]      o_result_row;
    logic [imconv_pkg::OUT_COL_W-1:0]      o_result_column;
    logic                                  o_frame_last;

    // predictor copy of registers and state
    logic [imconv_pkg::WIDTH_W-1:0]        cfg_width;
    logic [imconv_pkg::HEIGHT_W-1:0]       cfg_height;
    logic [imconv_pkg::KROW_W-1:0]         cfg_ktop;
    logic [imconv_pkg::KROW_W-1:0]         cfg_kmid;
    logic [imconv_pkg::KROW_W-1:0]         cfg_kbot;
    imconv_pkg::t_pix                      upper_line [LINE_DEPTH];
    imconv_pkg::t_pix                      lower_line [LINE_DEPTH];
    imconv_pkg::t_pix                      window [9];
    int unsigned                           in_col;
    int unsigned                           in_row;
    bit                                    frame_ended;
    t_conv_result                          results_due [$];

    int                        send_idle = 0;
    int                        stall_pct = 0;
    int                        hold_request = 0;
    int                        hold_left = 0;
    int                        quiet_cycles = 0;
    int                        mismatches = 0;
    int                        items_sent = 0;

    image_convolution_3x3 i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_pix_valid     (i_pix_valid),
        .o_pix_ready     (o_pix_ready),
        .i_pixel         (i_pixel),
        .i_flush         (i_flush),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_filtered      (o_filtered),
        .o_clamped_pixel (o_clamped_pixel),
        .o_result_row    (o_result_row),
        .o_result_column (o_result_column),
        .o_frame_last    (o_frame_last)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // window update and correlation for one accepted pixel transaction
    task automatic advance_window(input imconv_pkg::t_pix pix, input logic flush);
        int unsigned w, h, ic, ir, crow, ccol;
        imconv_pkg::t_pix v, above, prev;
        logic [imconv_pkg::KROW_W-1:0] krow;
        logic signed [imconv_pkg::COEF_W-1:0] c;
        bit emit;
        int sum;
        t_conv_result r;
        w = (cfg_width == 0) ? 1 : ((cfg_width > LINE_DEPTH) ? LINE_DEPTH : cfg_width);
        h = (cfg_height == 0) ? 1 : cfg_height;
        v = flush ? '0 : pix;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        ic = in_col;
        ir = in_row;
        above = upper_line[ic];
        prev = lower_line[ic];
        upper_line[ic] = prev;
        lower_line[ic] = v;
        for (int y = 0; y < 3; y++) begin
            window[y*3] = window[y*3+1];
            window[y*3+1] = window[y*3+2];
        end
        window[2] = above;
        window[5] = prev;
        window[8] = v;
        if (ic >= 1) begin
            emit = (ir >= 1);
            crow = ir - 1;
            ccol = ic - 1;
        end else begin
            emit = (ir >= 2);
            crow = ir - 2;
            ccol = w - 1;
        end
        in_col = ic + 1;
        if (in_col >= w) begin
            in_col = 0;
            if (in_row < 'h1FFFF) in_row++;
        end
        if (emit) begin
            sum = 0;
            for (int y = 0; y < 3; y++) begin
                krow = (y == 0) ? cfg_ktop : ((y == 1) ? cfg_kmid : cfg_kbot);
                if (y == 0 && crow == 0) continue;
                if (y == 2 && crow + 1 >= h) continue;
                for (int x = 0; x < 3; x++) begin
                    if (x == 0 && ccol == 0) continue;
                    if (x == 2 && ccol + 1 >= w) continue;
                    c = krow[x*imconv_pkg::COEF_W +: imconv_pkg::COEF_W];
                    sum += int'(window[y*3+x]) * int'(c);
                end
            end
            r.filtered = sum[imconv_pkg::SUM_W-1:0];
            r.clamped = (sum < 0) ? 8'd0 : ((sum >= 65536) ? 8'd255 : sum[15:8]);
            r.row = crow[imconv_pkg::OUT_ROW_W-1:0];
            r.col = ccol[imconv_pkg::OUT_COL_W-1:0];
            r.last = (crow + 1 >= h) && (ccol + 1 >= w);
            results_due.push_back(r);
            if (r.last) begin
                in_col = 0;
                in_row = 0;
                frame_ended = 1'b1;
            end
        end
    endtask

    task automatic send_pixel(input imconv_pkg::t_pix pix, input logic flush);
        i_pix_valid <= 1'b1;
        i_pixel <= pix;
        i_flush <= flush;
        do @(posedge i_clk); while (!o_pix_ready);
        advance_window(pix, flush);
        items_sent++;
        while ($urandom_range(0, 99) < send_idle) begin
            i_pix_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input imconv_pkg::t_reg_idx idx,
                             input logic [imconv_pkg::DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            imconv_pkg::REG_WIDTH:  cfg_width = value[imconv_pkg::WIDTH_W-1:0];
            imconv_pkg::REG_HEIGHT: cfg_height = value[imconv_pkg::HEIGHT_W-1:0];
            imconv_pkg::REG_KTOP:   cfg_ktop = value[imconv_pkg::KROW_W-1:0];
            imconv_pkg::REG_KMID:   cfg_kmid = value[imconv_pkg::KROW_W-1:0];
            imconv_pkg::REG_KBOT:   cfg_kbot = value[imconv_pkg::KROW_W-1:0];
            default:    ;
        endcase
    endtask

    // sender stops until all results are in, then lets the pipeline drain
    task automatic settle();
        i_pix_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_frame(input int w, input int h);
        write_reg(imconv_pkg::REG_WIDTH,
                  imconv_pkg::DATA_W'(w[imconv_pkg::WIDTH_W-1:0]));
        write_reg(imconv_pkg::REG_HEIGHT,
                  imconv_pkg::DATA_W'(h[imconv_pkg::HEIGHT_W-1:0]));
    endtask

    task automatic set_kernel(input logic [imconv_pkg::KROW_W-1:0] top,
                              input logic [imconv_pkg::KROW_W-1:0] mid,
                              input logic [imconv_pkg::KROW_W-1:0] bot);
        write_reg(imconv_pkg::REG_KTOP, imconv_pkg::DATA_W'(top));
        write_reg(imconv_pkg::REG_KMID, imconv_pkg::DATA_W'(mid));
        write_reg(imconv_pkg::REG_KBOT, imconv_pkg::DATA_W'(bot));
    endtask

    function automatic imconv_pkg::t_pix random_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return imconv_pkg::t_pix'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [imconv_pkg::COEF_W-1:0] random_coef();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4, 5:    return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 1024)) - 16'd512;
        endcase
    endfunction

    function automatic logic [imconv_pkg::KROW_W-1:0] random_krow();
        return {random_coef(), random_coef(), random_coef()};
    endfunction

    // drain items until the frame's last result is due; noise mixes in stray pixels
    task automatic finish_frame(input bit noise);
        while (!frame_ended) begin
            if (noise && $urandom_range(0, 9) == 0) send_pixel(random_pixel(), 1'b0);
            else send_pixel(random_pixel(), 1'b1);
        end
    endtask

    task automatic send_frame(input int npix, input bit noise);
        frame_ended = 1'b0;
        for (int i = 0; i < npix; i++)
            send_pixel(random_pixel(), noise && $urandom_range(0, 19) == 0);
        finish_frame(noise);
    endtask

    task automatic test_directed_frames();
        set_frame(3, 3);
        frame_ended = 1'b0;
        for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'hFF : 8'h00, 1'b0);
        finish_frame(1'b0);
        settle();
        set_frame(2, 2);
        set_kernel({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        frame_ended = 1'b0;
        repeat (4) send_pixel(8'hFF, 1'b0);
        finish_frame(1'b0);
        settle();
        set_kernel({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        frame_ended = 1'b0;
        repeat (4) send_pixel(8'hFF, 1'b0);
        finish_frame(1'b0);
        settle();
        // zero width and height both act as one
        set_frame(0, 0);
        send_frame(1, 1'b0);
    endtask

    task automatic test_wide_line();
        settle();
        set_frame(160, 2);
        set_kernel(random_krow(), random_krow(), random_krow());
        send_frame(320, 1'b0);
    endtask

    task automatic test_mid_frame_change();
        send_idle = 37;
        stall_pct = 37;
        settle();
        set_frame(2048, 3);
        frame_ended = 1'b0;
        repeat (5) send_pixel(random_pixel(), 1'b0);
        settle();
        write_reg(imconv_pkg::REG_WIDTH, imconv_pkg::DATA_W'(3));
        finish_frame(1'b1);
        settle();
        set_frame(4, 65535);
        frame_ended = 1'b0;
        repeat (22) send_pixel(random_pixel(), 1'b0);
        settle();
        write_reg(imconv_pkg::REG_HEIGHT, imconv_pkg::DATA_W'(2));
        finish_frame(1'b1);
    endtask

    task automatic test_backpressure();
        send_idle = 0;
        stall_pct = 0;
        settle();
        set_frame(2, 20);
        hold_request = HOLD_CYCLES;
        send_frame(40, 1'b0);
        settle();
    endtask

    task automatic test_random_frames(input int s_idle, input int r_stall, input int n_items);
        int target, w, h;
        send_idle = s_idle;
        stall_pct = r_stall;
        target = items_sent + n_items;
        while (items_sent < target) begin
            settle();
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
            h = $urandom_range(1, 10);
            set_frame(w, h);
            set_kernel(random_krow(), random_krow(), random_krow());
            if ($urandom_range(0, 7) == 0) begin
                frame_ended = 1'b0;
                repeat ($urandom_range(1, w * h)) send_pixel(random_pixel(), 1'b0);
                settle();
                set_frame($urandom_range(1, 24), $urandom_range(1, 10));
                finish_frame(1'b1);
            end else begin
                send_frame(w * h, 1'b1);
            end
        end
    endtask

    task automatic check_field(input string name, input logic signed [63:0] expected,
                               input logic signed [63:0] actual);
        if (expected !== actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_conv_result due;
        if (i_rst_n) begin
            if (o_res_valid && i_res_ready) begin
                if (results_due.size() == 0) begin
                    $error("result with none due: row %0d column %0d",
                           o_result_row, o_result_column);
                    mismatches++;
                end else begin
                    due = results_due.pop_front();
                    check_field("filtered", 64'(due.filtered), 64'(o_filtered));
                    check_field("clamped_pixel", 64'(due.clamped), 64'(o_clamped_pixel));
                    check_field("result_row", 64'(due.row), 64'(o_result_row));
                    check_field("result_column", 64'(due.col), 64'(o_result_column));
                    check_field("frame_last", 64'(due.last), 64'(o_frame_last));
                end
            end
            if ((i_pix_valid && o_pix_ready) || (o_res_valid && i_res_ready) ||
                (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        cfg_width = imconv_pkg::RST_WIDTH;
        cfg_height = imconv_pkg::RST_HEIGHT;
        cfg_ktop = imconv_pkg::RST_KTOP;
        cfg_kmid = imconv_pkg::RST_KMID;
        cfg_kbot = imconv_pkg::RST_KBOT;
        foreach (upper_line[i]) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        foreach (window[i]) window[i] = '0;
        in_col = 0;
        in_row = 0;
        frame_ended = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_wide_line();
        test_mid_frame_change();
        test_backpressure();
        test_random_frames(0, 0, 210);
        test_random_frames(79, 0, 210);
        test_random_frames(0, 79, 210);
        test_random_frames(37, 37, 210);
        settle();

        if (mismatches == 0 && results_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/imconv_pkg.sv
hdl/image_convolution_3x3.sv
bench/tb.sv
